/* design/bb3_pkg.sv */
// -----------------------------------------------------------------------------
// Box blur 3x3 package
// Shared widths, codes, payload types and a helper function of the blur block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

	// Fixed field widths.
	localparam int CHAN_W     = 8;
	localparam int PIX_W      = 3 * CHAN_W;
	localparam int CFG_DATA_W = 11;

	// A 3x3 sum of 8-bit values reaches 9 * 255 = 2295.
	localparam int SUM_W = 12;

	// Floor division by 9 as a multiply by a rounded-up reciprocal. The error
	// stays below 1/9 for every sum up to 2295, so the quotient is exact.
	localparam int RECIP_9     = 7282;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = SUM_W + 14;

	// Frame size limits and reset values.
	localparam int MIN_WIDTH          = 3;
	localparam int MIN_HEIGHT         = 1;
	localparam int FRAME_WIDTH_RESET  = 800;
	localparam int FRAME_HEIGHT_RESET = 600;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} opcode_t;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
	} sums_t;

	// Per-item control that travels with a pixel into the window stage.
	typedef struct packed {
		logic use_upper;
		logic use_middle;
		logic emit;
		logic last;
		logic top_ok;
		logic bottom_ok;
		logic left_ok;
		logic right_ok;
	} s1_ctrl_t;

	function automatic int clamp_int(input int v, input int lo, input int hi);
		int r;
		r = v;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/bb3_pix_if.sv */
// -----------------------------------------------------------------------------
// Box blur pixel channel
// Valid/ready channel that carries one input pixel or drain tick.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bb3_pix_if
	import bb3_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [CHAN_W-1:0] in_red;
	logic [CHAN_W-1:0] in_green;
	logic [CHAN_W-1:0] in_blue;

	modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
	modport sink (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

/* design/bb3_res_if.sv */
// -----------------------------------------------------------------------------
// Box blur result channel
// Valid/ready channel that carries one blurred pixel.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bb3_res_if
	import bb3_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] out_red;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_blue;
	logic              frame_end;

	modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
	modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

`default_nettype wire

/* design/bb3_cfg_if.sv */
// -----------------------------------------------------------------------------
// Box blur configuration channel
// Valid/ready write channel that carries a register index and write data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bb3_cfg_if
	import bb3_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic                  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/box_blur_3x3_rgb_unit.sv */
// -----------------------------------------------------------------------------
// 3x3 RGB box blur
// Streaming 3x3 box blur over a raster RGB frame with zero-padded borders.
// -----------------------------------------------------------------------------
// The block takes an RGB frame in raster order, one pixel per transfer, and
// returns each pixel's 3x3 neighborhood average (per channel sum divided by
// nine with floor, pixels outside the frame counted as zero, so borders come
// out darker). Results leave in raster order, frame_width+1 input transfers
// behind the inputs; after the last pixel of a frame, frame_width+1 drain
// ticks flush the rest, and frame_end marks the frame's last result. Drain
// ticks sent while the frame is still arriving, and drains beyond the flush,
// produce nothing; a pixel sent during the flush counts as a drain. The block
// accepts one transfer per clock unless a stalled output backs it up, and is
// fully pipelined: input counters and a line store read, then the window
// shift and masked sums, then the divide by nine into the output register.
// The throughput of one item per clock is set by the two line stores, each
// read once and written once per pixel. Writing frame_width or frame_height
// (sizes clamp to 3..MAX_WIDTH and 1..MAX_HEIGHT) restarts the frame; write
// them only while the block is idle. The line stores need no clearing after
// reset, so the block is ready at once.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_rgb_unit
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bb3_pix_if.sink   pixels,
	bb3_res_if.source results,
	bb3_cfg_if.sink   cfg
);

	// Column index into the line stores, width counter, and row counter; the
	// input row runs one past the frame height during the flush.
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

	logic             pix_accept;
	logic             cfg_we;
	logic             s1_free;
	logic             s1_move;
	logic             s1_valid;
	s1_ctrl_t         s1_ctrl;
	pixel_t           s1_pix;
	logic [COL_W-1:0] s1_col;
	logic [COL_W-1:0] rd_addr;
	logic             restart;
	pixel_t           upper_rd;
	pixel_t           middle_rd;
	pixel_t           upper_wdata;
	pixel_t           middle_wdata;
	logic             s2_valid;
	sums_t            s2_sums;
	logic             s2_last;
	logic             out_free;

	// The first stage takes a new transfer whenever it is empty or its item
	// moves on in the same clock; a stalled output only backs up the pipe
	// once every stage in front of it is occupied.
	assign s1_free      = !s1_valid || s1_move;
	assign pixels.ready = s1_free;
	assign pix_accept   = pixels.valid && pixels.ready;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	bb3_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COL_W      (COL_W),
		.WID_W      (WID_W),
		.ROW_W      (ROW_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (pix_accept),
		.opcode    (pixels.opcode),
		.color     ({pixels.in_red, pixels.in_green, pixels.in_blue}),
		.cfg_we    (cfg_we),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.s1_free   (s1_free),
		.rd_addr   (rd_addr),
		.restart   (restart),
		.s1_valid  (s1_valid),
		.s1_ctrl   (s1_ctrl),
		.s1_pix    (s1_pix),
		.s1_col    (s1_col)
	);

	// Both stores are read at the accepted pixel's column and written back
	// when that pixel leaves the first stage: the upper store takes the old
	// middle row, the middle store takes the new pixel. Consecutive pixels
	// address different columns, so a read never needs a write of the same
	// clock, except right after a restart, when the row read is unused.
	bb3_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W),
		.DATA_W (PIX_W)
	) u_upper_mem (
		.clk   (clk),
		.we    (s1_move),
		.waddr (s1_col),
		.wdata (upper_wdata),
		.re    (s1_free),
		.raddr (rd_addr),
		.rdata (upper_rd)
	);

	bb3_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W),
		.DATA_W (PIX_W)
	) u_middle_mem (
		.clk   (clk),
		.we    (s1_move),
		.waddr (s1_col),
		.wdata (middle_wdata),
		.re    (s1_free),
		.raddr (rd_addr),
		.rdata (middle_rd)
	);

	bb3_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (restart),
		.s1_valid     (s1_valid),
		.s1_ctrl      (s1_ctrl),
		.s1_pix       (s1_pix),
		.upper_rd     (upper_rd),
		.middle_rd    (middle_rd),
		.out_free     (out_free),
		.s1_move      (s1_move),
		.upper_wdata  (upper_wdata),
		.middle_wdata (middle_wdata),
		.s2_valid     (s2_valid),
		.s2_sums      (s2_sums),
		.s2_last      (s2_last)
	);

	bb3_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_valid (s2_valid),
		.s2_sums  (s2_sums),
		.s2_last  (s2_last),
		.out_free (out_free),
		.results  (results)
	);

`ifndef SYNTHESIS
	// Input back-pressure only ever comes from an occupied first stage.
	a_ready_low_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> s1_valid)
		else $error("input stalled while the first stage is empty");

	// A sum waiting on a full output register must not be lost.
	a_sums_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid && !out_free) |=> s2_valid)
		else $error("sum stage dropped an item while the output was full");

	// A new result can only come from the sum stage.
	a_result_from_sums: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(s2_valid))
		else $error("result appeared without a sum stage item");
`endif

endmodule

`default_nettype wire

/* design/bb3_line_mem.sv */
// -----------------------------------------------------------------------------
// Box blur line store
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb3_line_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 24
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* design/bb3_front.sv */
// -----------------------------------------------------------------------------
// Box blur front end
// Frame size registers, raster counters and the first pipeline stage.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb3_front
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int COL_W      = 10,
	parameter int WID_W      = 11,
	parameter int ROW_W      = 11
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic                  opcode,
	input  wire pixel_t                color,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s1_free,
	output      logic [COL_W-1:0]      rd_addr,
	output      logic                  restart,
	output      logic                  s1_valid,
	output      s1_ctrl_t              s1_ctrl,
	output      pixel_t                s1_pix,
	output      logic [COL_W-1:0]      s1_col
);

	localparam logic [WID_W-1:0] W_RESET =
		WID_W'(clamp_int(FRAME_WIDTH_RESET, MIN_WIDTH, MAX_WIDTH));
	localparam logic [ROW_W-1:0] H_RESET =
		ROW_W'(clamp_int(FRAME_HEIGHT_RESET, MIN_HEIGHT, MAX_HEIGHT));

	logic [WID_W-1:0] w_q;
	logic [ROW_W-1:0] h_q;
	logic [COL_W-1:0] ic_q;
	logic [ROW_W-1:0] ir_q;
	logic [COL_W-1:0] ocol_q;
	logic [ROW_W-1:0] orow_q;

	logic             s1_valid_s1;
	s1_ctrl_t         s1_ctrl_s1;
	pixel_t           s1_pix_s1;
	logic [COL_W-1:0] s1_col_s1;

	logic             receiving;
	logic             take;
	logic             emit;
	logic             last;
	logic             col_wrap;
	logic             ocol_wrap;
	logic [WID_W-1:0] cfg_w;
	logic [ROW_W-1:0] cfg_h;
	s1_ctrl_t         ctrl;

	always_comb begin
		receiving = ir_q < h_q;
		take      = accept && !(receiving && (opcode == OP_DRAIN));
		emit      = (ir_q >= ROW_W'(2)) || ((ir_q == ROW_W'(1)) && (ic_q != '0));
		last      = emit && (orow_q == h_q - ROW_W'(1))
			&& (WID_W'(ocol_q) == w_q - WID_W'(1));
		col_wrap  = (WID_W'(ic_q) + WID_W'(1)) == w_q;
		ocol_wrap = (WID_W'(ocol_q) + WID_W'(1)) == w_q;

		ctrl.use_upper  = ir_q >= ROW_W'(2);
		ctrl.use_middle = (ir_q != '0) && (ir_q <= h_q);
		ctrl.emit       = emit;
		ctrl.last       = last;
		ctrl.top_ok     = orow_q != '0;
		ctrl.bottom_ok  = (orow_q + ROW_W'(1)) < h_q;
		ctrl.left_ok    = ocol_q != '0;
		ctrl.right_ok   = !ocol_wrap;

		cfg_w = WID_W'(clamp_int(int'(cfg_data), MIN_WIDTH, MAX_WIDTH));
		cfg_h = ROW_W'(clamp_int(int'(cfg_data), MIN_HEIGHT, MAX_HEIGHT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= W_RESET;
			h_q    <= H_RESET;
			ic_q   <= '0;
			ir_q   <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					w_q <= cfg_w;
				end
				REG_FRAME_HEIGHT: begin
					h_q <= cfg_h;
				end
				default: begin
				end
			endcase
			ic_q   <= '0;
			ir_q   <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (take) begin
			if (last) begin
				ic_q   <= '0;
				ir_q   <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				if (col_wrap) begin
					ic_q <= '0;
					ir_q <= ir_q + ROW_W'(1);
				end else begin
					ic_q <= ic_q + COL_W'(1);
				end
				if (emit) begin
					if (ocol_wrap) begin
						ocol_q <= '0;
						orow_q <= orow_q + ROW_W'(1);
					end else begin
						ocol_q <= ocol_q + COL_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_free) begin
			s1_valid_s1 <= take;
		end
	end

	// Payload of the first stage; a pixel that arrives during the flush
	// counts as a drain tick, so its color is replaced by zero.
	always_ff @(posedge clk) begin
		if (take) begin
			s1_ctrl_s1 <= ctrl;
			s1_pix_s1  <= receiving ? color : '0;
			s1_col_s1  <= ic_q;
		end
	end

	assign rd_addr  = ic_q;
	assign restart  = cfg_we;
	assign s1_valid = s1_valid_s1;
	assign s1_ctrl  = s1_ctrl_s1;
	assign s1_pix   = s1_pix_s1;
	assign s1_col   = s1_col_s1;

endmodule

`default_nettype wire

/* design/bb3_window.sv */
// -----------------------------------------------------------------------------
// Box blur window
// 3x3 neighborhood registers, line store write-back and masked channel sums.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb3_window
	import bb3_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     restart,
	input  wire logic     s1_valid,
	input  wire s1_ctrl_t s1_ctrl,
	input  wire pixel_t   s1_pix,
	input  wire pixel_t   upper_rd,
	input  wire pixel_t   middle_rd,
	input  wire logic     out_free,
	output      logic     s1_move,
	output      pixel_t   upper_wdata,
	output      pixel_t   middle_wdata,
	output      logic     s2_valid,
	output      sums_t    s2_sums,
	output      logic     s2_last
);

	pixel_t     win_q [3][3];
	pixel_t     shifted [3][3];
	pixel_t     col_in [3];
	logic [2:0] row_ok;
	logic [2:0] col_ok;
	sums_t      sums;
	logic       s2_free;

	logic       s2_valid_s2;
	sums_t      s2_sums_s2;
	logic       s2_last_s2;

	always_comb begin
		col_in[0] = s1_ctrl.use_upper ? upper_rd : '0;
		col_in[1] = s1_ctrl.use_middle ? middle_rd : '0;
		col_in[2] = s1_pix;
		row_ok    = {s1_ctrl.bottom_ok, 1'b1, s1_ctrl.top_ok};
		col_ok    = {s1_ctrl.right_ok, 1'b1, s1_ctrl.left_ok};
		sums      = '0;
		for (int r = 0; r < 3; r++) begin
			shifted[r][0] = win_q[r][1];
			shifted[r][1] = win_q[r][2];
			shifted[r][2] = col_in[r];
		end
		// Neighbors that fall outside the frame count as zero.
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_ok[r] && col_ok[c]) begin
					sums.red   = sums.red + SUM_W'(shifted[r][c][2*CHAN_W +: CHAN_W]);
					sums.green = sums.green + SUM_W'(shifted[r][c][CHAN_W +: CHAN_W]);
					sums.blue  = sums.blue + SUM_W'(shifted[r][c][0 +: CHAN_W]);
				end
			end
		end
	end

	assign s2_free      = !s2_valid_s2 || out_free;
	assign s1_move      = s1_valid && (!s1_ctrl.emit || s2_free);
	assign upper_wdata  = col_in[1];
	assign middle_wdata = col_in[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (restart || (s1_move && s1_ctrl.last)) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (s1_move) begin
			win_q <= shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (s2_free) begin
			s2_valid_s2 <= s1_move && s1_ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_ctrl.emit) begin
			s2_sums_s2 <= sums;
			s2_last_s2 <= s1_ctrl.last;
		end
	end

	assign s2_valid = s2_valid_s2;
	assign s2_sums  = s2_sums_s2;
	assign s2_last  = s2_last_s2;

endmodule

`default_nettype wire

/* design/bb3_out.sv */
// -----------------------------------------------------------------------------
// Box blur output stage
// Divides the channel sums by nine and holds the result for the sink.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb3_out
	import bb3_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s2_valid,
	input  wire sums_t     s2_sums,
	input  wire logic      s2_last,
	output      logic      out_free,
	bb3_res_if.source      results
);

	logic [PROD_W-1:0] prod_red;
	logic [PROD_W-1:0] prod_green;
	logic [PROD_W-1:0] prod_blue;

	logic              valid_q;
	logic [CHAN_W-1:0] red_q;
	logic [CHAN_W-1:0] green_q;
	logic [CHAN_W-1:0] blue_q;
	logic              frame_end_q;

	always_comb begin
		prod_red   = PROD_W'(s2_sums.red) * PROD_W'(RECIP_9);
		prod_green = PROD_W'(s2_sums.green) * PROD_W'(RECIP_9);
		prod_blue  = PROD_W'(s2_sums.blue) * PROD_W'(RECIP_9);
	end

	assign out_free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_valid) begin
			red_q       <= prod_red[RECIP_SHIFT +: CHAN_W];
			green_q     <= prod_green[RECIP_SHIFT +: CHAN_W];
			blue_q      <= prod_blue[RECIP_SHIFT +: CHAN_W];
			frame_end_q <= s2_last;
		end
	end

	assign results.valid     = valid_q;
	assign results.out_red   = red_q;
	assign results.out_green = green_q;
	assign results.out_blue  = blue_q;
	assign results.frame_end = frame_end_q;

endmodule

`default_nettype wire

/* verif/box_blur_3x3_rgb_unit_test.sv */
// -----------------------------------------------------------------------------
// 3x3 RGB box blur testbench
// Streams raster frames through the blur block and checks each blurred pixel
// against a cycle-free model of the blur kept inside a small scoreboard.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_blur_3x3_rgb_unit_test;
	import bb3_pkg::*;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 1024;

	// Cycles with no transfer on any channel before the run is declared hung.
	localparam int STALL_LIMIT = 4000;
	// Length of the long output hold-off that backs the block up to its input.
	localparam int HOLDOFF_CYCLES = 300;
	// Random items after the directed part and the size extremes.
	localparam int RANDOM_ITEMS = 1200;
	// From this many random items on, neither side idles any more.
	localparam int QUIET_FROM = 1000;

	// One blurred pixel as it leaves the block.
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              frame_end;
	} blurred_t;

	// The scoreboard carries its own copy of the line stores, the window and
	// the four raster counters. Each accepted input item is run through the
	// blur at once, and whatever it emits is queued until the block delivers it.
	class blur_tracker;
		pixel_t      upper_row [MAX_W];
		pixel_t      middle_row [MAX_W];
		pixel_t      window [9];
		int unsigned in_col, in_row, out_col, out_row;
		logic [CFG_DATA_W-1:0] width_reg, height_reg;
		blurred_t    blurred_due [$];
		int unsigned errors, printed, compared;

		function new();
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			width_reg = 11'd800;
			height_reg = 11'd600;
			restart();
			errors = 0;
			printed = 0;
			compared = 0;
		endfunction

		static function int unsigned clamp_size(int unsigned v, int unsigned lo,
				int unsigned hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function int unsigned cols();
			return clamp_size(width_reg, 3, MAX_W);
		endfunction

		function int unsigned rows();
			return clamp_size(height_reg, 1, MAX_H);
		endfunction

		function void restart();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			foreach (window[i])
				window[i] = '0;
		endfunction

		// Either size write restarts the frame and drops whatever was pending.
		function void set_size(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
			if (idx == REG_FRAME_WIDTH)
				width_reg = v;
			else
				height_reg = v;
			restart();
		endfunction

		// Runs one accepted item through the blur. Returns 0 when the item is a
		// drain tick that the block ignores because the frame is still arriving.
		function bit take_pixel(opcode_t op, pixel_t color);
			int unsigned w, h, ir, ic, rr, cc;
			int unsigned red_acc, green_acc, blue_acc;
			bit          receiving, emit, last;
			pixel_t      col [3];
			pixel_t      px;
			blurred_t    res;

			w = cols();
			h = rows();
			ir = in_row;
			ic = in_col;
			receiving = ir < h;
			if (ic >= w) begin
				restart();
				ir = 0;
				ic = 0;
				receiving = 1'b1;
			end
			if (receiving && op == OP_DRAIN)
				return 1'b0;

			// Once every pixel is in, the item only pushes zeros through.
			col[2] = receiving ? color : '0;
			col[0] = (ir >= 2 && ir - 2 < h) ? upper_row[ic] : '0;
			col[1] = (ir >= 1 && ir - 1 < h) ? middle_row[ic] : '0;
			upper_row[ic] = col[1];
			middle_row[ic] = col[2];
			for (rr = 0; rr < 3; rr++) begin
				window[rr*3] = window[rr*3+1];
				window[rr*3+1] = window[rr*3+2];
				window[rr*3+2] = col[rr];
			end

			emit = ir >= 2 || (ir == 1 && ic >= 1);
			ic++;
			if (ic >= w) begin
				ic = 0;
				ir++;
			end
			in_col = ic;
			in_row = ir;
			if (!emit)
				return 1'b1;

			// Window taps that fall outside the frame are left out of the sums.
			red_acc = 0;
			green_acc = 0;
			blue_acc = 0;
			for (rr = 0; rr < 3; rr++) begin
				for (cc = 0; cc < 3; cc++) begin
					if ((rr == 0 && out_row == 0) || (rr == 2 && out_row + 1 >= h) ||
							(cc == 0 && out_col == 0) || (cc == 2 && out_col + 1 >= w))
						continue;
					px = window[rr*3+cc];
					red_acc += px[23:16];
					green_acc += px[15:8];
					blue_acc += px[7:0];
				end
			end
			last = (out_row == h - 1) && (out_col == w - 1);
			res.red = CHAN_W'(red_acc / 9);
			res.green = CHAN_W'(green_acc / 9);
			res.blue = CHAN_W'(blue_acc / 9);
			res.frame_end = last;
			blurred_due.push_back(res);

			if (last) begin
				restart();
			end else begin
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
			return 1'b1;
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (printed < 40) begin
				printed++;
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
		endtask

		task compare_blurred(blurred_t got);
			blurred_t want;

			if (blurred_due.size() == 0) begin
				report_mismatch($sformatf("blurred pixel %h with none due", got));
				return;
			end
			want = blurred_due.pop_front();
			compared++;
			if (got.red !== want.red)
				report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
			if (got.green !== want.green)
				report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
			if (got.blue !== want.blue)
				report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
			if (got.frame_end !== want.frame_end)
				report_mismatch($sformatf("frame_end %b, want %b", got.frame_end,
					want.frame_end));
		endtask
	endclass

	logic clk;
	logic arst_n;

	bb3_pix_if pix_ch ();
	bb3_res_if res_ch ();
	bb3_cfg_if cfg_ch ();

	box_blur_3x3_rgb_unit #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix_ch),
		.results(res_ch),
		.cfg(cfg_ch)
	);

	blur_tracker tracker = new();

	// Shared between the stimulus and the result sink.
	bit          quiet;              // no random idling from here on
	bit          long_holdoff_due;   // asks the sink for one long hold-off
	int unsigned items_taken;        // items the blur actually consumed
	int unsigned random_taken;       // the same, counted in the random part only
	int unsigned size_writes;
	int unsigned stall_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Every transfer on any channel resets the hang counter.
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("no transfer for %0d cycles, %0d blurred pixels still due",
			STALL_LIMIT, tracker.blurred_due.size());
		$display("FAIL");
		$finish;
	end

	// Every blurred pixel that the sink takes is compared with the oldest one due.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			tracker.compare_blurred({res_ch.out_red, res_ch.out_green, res_ch.out_blue,
				res_ch.frame_end});
	end

	// Result sink. It stalls in random bursts, once for a long stretch on request,
	// and stays ready throughout the quiet tail of the run. The countdown keeps
	// exactly one assignment to ready per falling edge.
	initial begin : result_sink
		int unsigned hold_left;

		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (long_holdoff_due) begin
				long_holdoff_due = 1'b0;
				hold_left = HOLDOFF_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(0, 18);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Mostly random colors, with a share of saturated and black channels so
	// that the sums reach both ends of their range.
	function automatic pixel_t pick_color();
		pixel_t c;

		c = pixel_t'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			c[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			c[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			c[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return c;
	endfunction

	// Offers one item and waits for its transfer. A random idle gap may come
	// first; valid stays high from one item to the next otherwise.
	task automatic send_item(opcode_t op, pixel_t color);
		int unsigned gap;

		if (!quiet && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			pix_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_ch.valid <= 1'b1;
		pix_ch.opcode <= op;
		pix_ch.in_red <= color[23:16];
		pix_ch.in_green <= color[15:8];
		pix_ch.in_blue <= color[7:0];
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		if (tracker.take_pixel(op, color))
			items_taken++;
	endtask

	// Waits until every blurred pixel due has arrived, then lets the pipeline
	// empty of items that produce nothing, so that the block is idle.
	task automatic settle();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (tracker.blurred_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_size(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		tracker.set_size(idx, v);
		size_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Writes both sizes in random order while the block is idle.
	task automatic configure(logic [CFG_DATA_W-1:0] wv, logic [CFG_DATA_W-1:0] hv);
		settle();
		if ($urandom_range(0, 1)) begin
			write_size(REG_FRAME_WIDTH, wv);
			write_size(REG_FRAME_HEIGHT, hv);
		end else begin
			write_size(REG_FRAME_HEIGHT, hv);
			write_size(REG_FRAME_WIDTH, wv);
		end
	endtask

	// Whole frames at the current size, each followed by its flush. A messy
	// frame adds drains while pixels still arrive, pixels during the flush and
	// surplus drains after the last result.
	task automatic run_frames(int unsigned frames, bit messy);
		int unsigned w, h, f, p;

		w = tracker.cols();
		h = tracker.rows();
		for (f = 0; f < frames; f++) begin
			for (p = 0; p < w * h; p++) begin
				if (messy && $urandom_range(0, 11) == 0)
					send_item(OP_DRAIN, pick_color());
				send_item(OP_PIXEL, pick_color());
			end
			for (p = 0; p <= w; p++) begin
				if (messy && $urandom_range(0, 3) == 0)
					send_item(OP_PIXEL, pick_color());
				else
					send_item(OP_DRAIN, pick_color());
			end
			if (messy)
				repeat ($urandom_range(0, 3)) send_item(OP_DRAIN, pick_color());
		end
	endtask

	task automatic run_noise(int unsigned n);
		repeat (n) send_item($urandom_range(0, 1) ? OP_DRAIN : OP_PIXEL, pick_color());
	endtask

	// A frame cut short; the next size write throws its pending results away.
	task automatic run_partial();
		int unsigned n;

		n = tracker.cols() * tracker.rows();
		n = $urandom_range(1, n + tracker.cols() - 1);
		repeat (n) send_item(OP_PIXEL, pick_color());
	endtask

	initial begin : stimulus
		int unsigned wv, hv, kind, taken_before;
		logic [CFG_DATA_W-1:0] extreme_w [5];
		logic [CFG_DATA_W-1:0] extreme_h [5];

		quiet = 1'b0;
		long_holdoff_due = 1'b0;
		items_taken = 0;
		random_taken = 0;
		size_writes = 0;
		stall_cycles = 0;
		pix_ch.valid = 1'b0;
		pix_ch.opcode = OP_PIXEL;
		pix_ch.in_red = '0;
		pix_ch.in_green = '0;
		pix_ch.in_blue = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_FRAME_WIDTH;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. A few pixels at the reset size, 800 by 600, produce
		// nothing yet; the size writes that follow restart the frame.
		repeat (4) send_item(OP_PIXEL, pick_color());

		// A width of zero runs as the minimum of three columns. The frame mixes
		// white and black with pure primaries, a drain arrives while the frame is
		// still coming in, a pixel lands in the flush, and two drains follow the
		// frame's last result.
		configure(11'd0, 11'd2);
		send_item(OP_PIXEL, 24'hFFFFFF);
		send_item(OP_DRAIN, 24'hFFFFFF);
		send_item(OP_PIXEL, 24'h000000);
		send_item(OP_PIXEL, 24'hFF0000);
		send_item(OP_PIXEL, 24'h00FF00);
		send_item(OP_PIXEL, 24'h0000FF);
		send_item(OP_PIXEL, 24'hFFFFFF);
		send_item(OP_DRAIN, 24'h000000);
		send_item(OP_PIXEL, 24'hFFFFFF);
		send_item(OP_DRAIN, 24'h000000);
		send_item(OP_DRAIN, 24'hFFFFFF);
		send_item(OP_DRAIN, 24'h000000);
		send_item(OP_DRAIN, 24'hFFFFFF);

		// The sink holds off for a long stretch while a frame keeps coming, so
		// the block fills up and has to stall its input.
		configure(11'd10, 11'd6);
		long_holdoff_due = 1'b1;
		run_frames(1, 1'b0);

		// Small size extremes: zero and other values below the minimum, the
		// minimum itself, and one wider frame that reaches further into the
		// line stores.
		extreme_w = '{11'd1, 11'd0, 11'd3, 11'd2, 11'd64};
		extreme_h = '{11'd1, 11'd0, 11'd2, 11'd3, 11'd2};
		for (int i = 0; i < 5; i++) begin
			configure(extreme_w[i], extreme_h[i]);
			run_frames(1, i[0]);
		end

		// Random part: mostly well-formed frames of small random size, some
		// back to back without a size write in between, plus messy frames,
		// noise and frames cut short.
		while (random_taken < RANDOM_ITEMS) begin
			wv = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			hv = $urandom_range(0, 7);
			kind = $urandom_range(0, 9);
			taken_before = items_taken;
			configure(CFG_DATA_W'(wv), CFG_DATA_W'(hv));
			case (kind)
				0, 1, 2, 3, 4, 5: begin
					run_frames($urandom_range(1, 3), 1'b0);
				end
				6, 7: begin
					run_frames($urandom_range(1, 2), 1'b1);
				end
				8: begin
					run_noise($urandom_range(1, 12));
					run_frames(1, 1'b0);
				end
				default: begin
					run_partial();
				end
			endcase
			random_taken += items_taken - taken_before;
			if (random_taken >= QUIET_FROM)
				quiet = 1'b1;
		end

		// Drain everything, give the pipeline time to show any stray result,
		// and make sure nothing is left waiting.
		settle();
		repeat (20) @(posedge clk);
		if (tracker.blurred_due.size() != 0)
			tracker.report_mismatch($sformatf("%0d blurred pixels never arrived",
				tracker.blurred_due.size()));

		$display("Blurred %0d items into %0d checked pixels over %0d size writes,",
			items_taken, tracker.compared, size_writes);
		$display("with sizes below and at the minimum, stray drains and stalls on both sides.");
		if (tracker.errors == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", tracker.errors);
			$display("FAIL");
		end
		$finish;
	end

endmodule
